### rtl/sorted_timer_queue_top_macros.svh
// Assertion macros shared by the timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_QUEUE_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define STQ_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("timer queue check failed");

// Consequence that must hold in the same cycle as the antecedent.
`define STQ_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Consequence that must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

### rtl/stq_pkg.sv
package stq_pkg;

  localparam int TIME_W      = 63;
  localparam int ID_W        = 4;
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] CMD_START       = 3'd0;
  localparam logic [2:0] CMD_START_DELTA = 3'd1;
  localparam logic [2:0] CMD_STOP        = 3'd2;
  localparam logic [2:0] CMD_RUN         = 3'd3;
  localparam logic [2:0] CMD_NEXT        = 3'd4;
  localparam logic [2:0] CMD_ADD         = 3'd5;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_STOPPED   = 3'd1;
  localparam logic [2:0] EV_FIRED     = 3'd2;
  localparam logic [2:0] EV_UNCHANGED = 3'd3;
  localparam logic [2:0] EV_ADDED     = 3'd4;
  localparam logic [2:0] EV_REJECTED  = 3'd5;
  localparam logic [2:0] EV_NEXT      = 3'd6;
  localparam logic [2:0] EV_NOTHING   = 3'd7;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [ID_W-1:0]   event_timer;
    logic              was_scheduled;
    logic [TIME_W-1:0] remaining;
    logic              queue_empty;
    logic              last;
  } res_t;

  // Outcome of the shared adder.
  typedef struct packed {
    logic              lt;
    logic              eq;
    logic [TIME_W-1:0] value;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_START_CHK,
    ST_EQ_CHK,
    ST_UL_RD,
    ST_UL_CHK,
    ST_LK_START,
    ST_LK_RD,
    ST_LK_EXP,
    ST_LK_CMP,
    ST_RUN_CHK,
    ST_RUN_ORD,
    ST_RUN_CMP,
    ST_RUN_END,
    ST_NX_ORD,
    ST_NX_CMP
  } st_e;

  // Where the sequencer resumes once an unlink walk is over.
  typedef enum logic [1:0] {
    RET_STOP,
    RET_RESTART,
    RET_RUN
  } ret_e;

endpackage

### rtl/stq_alu.sv
module stq_alu (
  input  logic [stq_pkg::TIME_W-1:0] a_i,
  input  logic [stq_pkg::TIME_W-1:0] b_i,
  input  logic                       sub_i,
  output stq_pkg::alu_res_t          res_o
);

  logic [stq_pkg::TIME_W:0] b_ext;
  logic [stq_pkg::TIME_W:0] sum;

  // Both operands stay below 2^63, so the top bit of a - b is its sign and
  // the top bit of a + b is the overflow that saturates.
  assign b_ext = sub_i ? ~{1'b0, b_i} : {1'b0, b_i};
  assign sum   = {1'b0, a_i} + b_ext + {{stq_pkg::TIME_W{1'b0}}, sub_i};

  always_comb begin
    res_o.lt = sub_i & sum[stq_pkg::TIME_W];
    res_o.eq = sub_i & (sum == '0);
    if (sub_i) begin
      res_o.value = sum[stq_pkg::TIME_W] ? '0 : sum[stq_pkg::TIME_W-1:0];
    end else begin
      res_o.value = sum[stq_pkg::TIME_W] ? '1 : sum[stq_pkg::TIME_W-1:0];
    end
  end

endmodule

### rtl/sorted_timer_queue_top.sv
// Channel  | Direction | Handshake                      | Payload
// request  | in        | start high and busy low        | req_i (cmd, timer_id, time, now)
// result   | out       | res_valid_o, one-cycle strobe  | res_o (event, timer, ..., last)
//
// Invalid requests, and a next on an empty queue, are answered at dispatch. A
// stop walks the order list to unlink its timer; a restart unlinks it, then
// walks back from the tail to relink. A run unlinks each fired timer in turn.
// The walks, one order memory read per step, and the shared adder set the time.
// Reset clears the pending flags and the count; memories need no clearing pass.
// Results are strobed and cannot be stalled; busy stays high until the last one.
`include "sorted_timer_queue_top_macros.svh"

module sorted_timer_queue_top #(
  parameter int NUM_TIMERS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  stq_pkg::req_t req_i,
  output logic          res_valid_o,
  output stq_pkg::res_t res_o
);

  localparam int AddrW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CntW  = $clog2(NUM_TIMERS + 1);

  stq_pkg::st_e  state_q, state_d;
  stq_pkg::req_t req_q, req_d;
  stq_pkg::ret_e ret_q, ret_d;
  stq_pkg::res_t res_q, emit_res;
  logic          res_valid_q, emit_v;

  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [CntW-1:0]               idx_q, idx_d, idx_m1;
  logic [NUM_TIMERS-1:0]         pend_q, pend_d;
  logic                          found_q, found_d;
  logic                          was_q, was_d;
  logic [stq_pkg::ID_W-1:0]      cur_q, cur_d;
  logic [stq_pkg::TIME_W-1:0]    exp_q, exp_d;
  logic [stq_pkg::FIRE_W-1:0]    fired_q, fired_d;
  logic                          hold_v_q, hold_v_d;
  logic [stq_pkg::ID_W-1:0]      hold_id_q, hold_id_d;

  logic [stq_pkg::ID_W-1:0]   ord_mem [NUM_TIMERS];
  logic [stq_pkg::TIME_W-1:0] exp_mem [NUM_TIMERS];
  logic [stq_pkg::ID_W-1:0]   ord_rd_q;
  logic [stq_pkg::TIME_W-1:0] exp_rd_q;
  logic                       ord_re, ord_we, exp_re, exp_we;
  logic [AddrW-1:0]           ord_raddr, ord_waddr, exp_raddr, exp_waddr;
  logic [stq_pkg::ID_W-1:0]   ord_wdata;
  logic [stq_pkg::TIME_W-1:0] exp_wdata;

  logic [stq_pkg::TIME_W-1:0] alu_a, alu_b;
  logic                       alu_sub;
  stq_pkg::alu_res_t          alu_res;

  logic             id_ok, slot_was, cnt_zero, cnt_full, lk_greater, run_stop;
  logic [AddrW-1:0] req_slot, cur_slot;

  function automatic stq_pkg::res_t mk_res(logic [2:0] ev, logic [stq_pkg::ID_W-1:0] id,
                                           logic was, logic lst);
    stq_pkg::res_t r;
    r               = '0;
    r.event_res     = ev;
    r.event_timer   = id;
    r.was_scheduled = was;
    r.last          = lst;
    return r;
  endfunction

  assign busy        = (state_q != stq_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign req_slot   = AddrW'(req_q.timer_id);
  assign cur_slot   = AddrW'(cur_q);
  assign id_ok      = (32'(req_q.timer_id) < 32'(NUM_TIMERS));
  assign slot_was   = pend_q[req_slot];
  assign cnt_zero   = (cnt_q == '0);
  assign cnt_full   = (cnt_q == CntW'(NUM_TIMERS));
  assign idx_m1     = idx_q - 1'b1;
  assign lk_greater = !alu_res.lt && !alu_res.eq;
  assign run_stop   = cnt_zero || (fired_q == stq_pkg::FIRE_W'(stq_pkg::MAX_RESULTS));

  // Shared adder: the saturating sum for a relative start, every expiry compare
  // and the time left to the head all go through it.
  always_comb begin
    alu_sub = (state_q != stq_pkg::ST_DISPATCH);
    alu_a   = (state_q == stq_pkg::ST_DISPATCH) ? req_q.now : exp_rd_q;
    if (state_q == stq_pkg::ST_DISPATCH) begin
      alu_b = req_q.time_value;
    end else if (state_q == stq_pkg::ST_EQ_CHK || state_q == stq_pkg::ST_LK_CMP) begin
      alu_b = exp_q;
    end else begin
      alu_b = req_q.now;
    end
  end

  stq_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      stq_pkg::ST_IDLE: begin
        if (start) state_d = stq_pkg::ST_DISPATCH;
      end
      stq_pkg::ST_DISPATCH: begin
        case (req_q.cmd)
          stq_pkg::CMD_RUN: state_d = stq_pkg::ST_RUN_CHK;
          stq_pkg::CMD_NEXT: state_d = cnt_zero ? stq_pkg::ST_IDLE : stq_pkg::ST_NX_ORD;
          stq_pkg::CMD_STOP: begin
            state_d = (id_ok && slot_was) ? stq_pkg::ST_UL_RD : stq_pkg::ST_IDLE;
          end
          stq_pkg::CMD_ADD: begin
            state_d = (id_ok && !slot_was) ? stq_pkg::ST_LK_START : stq_pkg::ST_IDLE;
          end
          stq_pkg::CMD_START, stq_pkg::CMD_START_DELTA: begin
            state_d = id_ok ? stq_pkg::ST_START_CHK : stq_pkg::ST_IDLE;
          end
          default: state_d = stq_pkg::ST_IDLE;
        endcase
      end
      stq_pkg::ST_START_CHK: state_d = was_q ? stq_pkg::ST_EQ_CHK : stq_pkg::ST_LK_START;
      stq_pkg::ST_EQ_CHK: state_d = alu_res.eq ? stq_pkg::ST_IDLE : stq_pkg::ST_UL_RD;
      stq_pkg::ST_UL_RD: begin
        if (idx_q == cnt_q) begin
          case (ret_q)
            stq_pkg::RET_RESTART: state_d = stq_pkg::ST_LK_START;
            stq_pkg::RET_RUN: state_d = stq_pkg::ST_RUN_CHK;
            default: state_d = stq_pkg::ST_IDLE;
          endcase
        end else begin
          state_d = stq_pkg::ST_UL_CHK;
        end
      end
      stq_pkg::ST_UL_CHK: state_d = stq_pkg::ST_UL_RD;
      stq_pkg::ST_LK_START: state_d = cnt_full ? stq_pkg::ST_IDLE : stq_pkg::ST_LK_RD;
      stq_pkg::ST_LK_RD: state_d = (idx_q == '0) ? stq_pkg::ST_IDLE : stq_pkg::ST_LK_EXP;
      stq_pkg::ST_LK_EXP: state_d = stq_pkg::ST_LK_CMP;
      stq_pkg::ST_LK_CMP: state_d = lk_greater ? stq_pkg::ST_LK_RD : stq_pkg::ST_IDLE;
      stq_pkg::ST_RUN_CHK: state_d = run_stop ? stq_pkg::ST_RUN_END : stq_pkg::ST_RUN_ORD;
      stq_pkg::ST_RUN_ORD: state_d = stq_pkg::ST_RUN_CMP;
      stq_pkg::ST_RUN_CMP: state_d = alu_res.lt ? stq_pkg::ST_UL_RD : stq_pkg::ST_RUN_END;
      stq_pkg::ST_RUN_END: state_d = stq_pkg::ST_IDLE;
      stq_pkg::ST_NX_ORD: state_d = stq_pkg::ST_NX_CMP;
      stq_pkg::ST_NX_CMP: state_d = stq_pkg::ST_IDLE;
      default: state_d = stq_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and results.
  always_comb begin
    req_d     = req_q;
    ret_d     = ret_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    found_d   = found_q;
    was_d     = was_q;
    cur_d     = cur_q;
    exp_d     = exp_q;
    fired_d   = fired_q;
    hold_v_d  = hold_v_q;
    hold_id_d = hold_id_q;
    emit_v    = 1'b0;
    emit_res  = '0;
    ord_re    = 1'b0;
    ord_raddr = '0;
    ord_we    = 1'b0;
    ord_waddr = idx_q[AddrW-1:0];
    ord_wdata = cur_q;
    exp_re    = 1'b0;
    exp_raddr = cur_slot;
    exp_we    = 1'b0;
    exp_waddr = cur_slot;
    exp_wdata = exp_q;

    case (state_q)
      stq_pkg::ST_IDLE: begin
        if (start) req_d = req_i;
      end
      stq_pkg::ST_DISPATCH: begin
        cur_d   = req_q.timer_id;
        idx_d   = '0;
        found_d = 1'b0;
        was_d   = id_ok && slot_was;
        ret_d   = stq_pkg::RET_STOP;
        exp_d   = (req_q.cmd == stq_pkg::CMD_START_DELTA) ? alu_res.value : req_q.time_value;
        case (req_q.cmd)
          stq_pkg::CMD_RUN: begin
            fired_d  = '0;
            hold_v_d = 1'b0;
          end
          stq_pkg::CMD_NEXT: begin
            if (cnt_zero) begin
              emit_v               = 1'b1;
              emit_res             = mk_res(stq_pkg::EV_NEXT, '0, 1'b0, 1'b1);
              emit_res.queue_empty = 1'b1;
            end else begin
              ord_re = 1'b1;
            end
          end
          stq_pkg::CMD_STOP, stq_pkg::CMD_ADD, stq_pkg::CMD_START,
          stq_pkg::CMD_START_DELTA: begin
            if (!id_ok) begin
              emit_v   = 1'b1;
              emit_res = mk_res(stq_pkg::EV_REJECTED, req_q.timer_id, 1'b0, 1'b1);
            end else if (req_q.cmd == stq_pkg::CMD_STOP && !slot_was) begin
              emit_v   = 1'b1;
              emit_res = mk_res(stq_pkg::EV_NOTHING, req_q.timer_id, 1'b0, 1'b1);
            end else if (req_q.cmd == stq_pkg::CMD_ADD && slot_was) begin
              emit_v   = 1'b1;
              emit_res = mk_res(stq_pkg::EV_REJECTED, req_q.timer_id, 1'b1, 1'b1);
            end
          end
          default: begin
            emit_v   = 1'b1;
            emit_res = mk_res(stq_pkg::EV_NOTHING, '0, 1'b0, 1'b1);
          end
        endcase
      end
      stq_pkg::ST_START_CHK: begin
        exp_re = was_q;
      end
      stq_pkg::ST_EQ_CHK: begin
        if (alu_res.eq) begin
          emit_v   = 1'b1;
          emit_res = mk_res(stq_pkg::EV_UNCHANGED, cur_q, 1'b1, 1'b1);
        end else begin
          ret_d   = stq_pkg::RET_RESTART;
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      stq_pkg::ST_UL_RD: begin
        if (idx_q == cnt_q) begin
          cnt_d            = cnt_q - 1'b1;
          pend_d[cur_slot] = 1'b0;
          case (ret_q)
            stq_pkg::RET_STOP: begin
              emit_v   = 1'b1;
              emit_res = mk_res(stq_pkg::EV_STOPPED, cur_q, 1'b1, 1'b1);
            end
            stq_pkg::RET_RESTART: begin
              emit_v   = 1'b1;
              emit_res = mk_res(stq_pkg::EV_STOPPED, cur_q, 1'b1, 1'b0);
            end
            default: ;
          endcase
        end else begin
          ord_re    = 1'b1;
          ord_raddr = idx_q[AddrW-1:0];
        end
      end
      stq_pkg::ST_UL_CHK: begin
        // Once the slot is found, every later entry moves up by one place.
        if (found_q) begin
          ord_we    = 1'b1;
          ord_waddr = idx_m1[AddrW-1:0];
          ord_wdata = ord_rd_q;
        end
        if (ord_rd_q == cur_q) found_d = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      stq_pkg::ST_LK_START: begin
        idx_d = cnt_q;
        if (cnt_full) begin
          emit_v = 1'b1;
          if (req_q.cmd == stq_pkg::CMD_ADD) begin
            emit_res = mk_res(stq_pkg::EV_ADDED, cur_q, 1'b0, 1'b1);
          end else begin
            emit_res = mk_res(stq_pkg::EV_STARTED, cur_q, was_q, 1'b1);
          end
        end
      end
      stq_pkg::ST_LK_RD, stq_pkg::ST_LK_CMP: begin
        // The list is walked from its tail; entries that expire later than
        // the new one move down, and the new slot lands after all equal ones.
        if (state_q == stq_pkg::ST_LK_RD && idx_q != '0) begin
          ord_re    = 1'b1;
          ord_raddr = idx_m1[AddrW-1:0];
        end else if (state_q == stq_pkg::ST_LK_CMP && lk_greater) begin
          ord_we    = 1'b1;
          ord_wdata = ord_rd_q;
          idx_d     = idx_m1;
        end else begin
          ord_we           = 1'b1;
          exp_we           = 1'b1;
          pend_d[cur_slot] = 1'b1;
          cnt_d            = cnt_q + 1'b1;
          emit_v           = 1'b1;
          if (req_q.cmd == stq_pkg::CMD_ADD) begin
            emit_res = mk_res(stq_pkg::EV_ADDED, cur_q, 1'b0, 1'b1);
          end else begin
            emit_res = mk_res(stq_pkg::EV_STARTED, cur_q, was_q, 1'b1);
          end
        end
      end
      stq_pkg::ST_LK_EXP, stq_pkg::ST_RUN_ORD, stq_pkg::ST_NX_ORD: begin
        exp_re    = 1'b1;
        exp_raddr = AddrW'(ord_rd_q);
      end
      stq_pkg::ST_RUN_CHK: begin
        ord_re = !run_stop;
      end
      stq_pkg::ST_RUN_CMP: begin
        // A fired timer is held back one step so that the final one of the
        // run can carry the last mark.
        if (alu_res.lt) begin
          if (hold_v_q) begin
            emit_v   = 1'b1;
            emit_res = mk_res(stq_pkg::EV_FIRED, hold_id_q, 1'b1, 1'b0);
          end
          hold_v_d  = 1'b1;
          hold_id_d = ord_rd_q;
          fired_d   = fired_q + 1'b1;
          cur_d     = ord_rd_q;
          ret_d     = stq_pkg::RET_RUN;
          idx_d     = '0;
          found_d   = 1'b0;
        end
      end
      stq_pkg::ST_RUN_END: begin
        emit_v = 1'b1;
        if (hold_v_q) begin
          emit_res = mk_res(stq_pkg::EV_FIRED, hold_id_q, 1'b1, 1'b1);
        end else begin
          emit_res = mk_res(stq_pkg::EV_NOTHING, '0, 1'b0, 1'b1);
        end
      end
      stq_pkg::ST_NX_CMP: begin
        emit_v             = 1'b1;
        emit_res           = mk_res(stq_pkg::EV_NEXT, ord_rd_q, 1'b0, 1'b1);
        emit_res.remaining = alu_res.value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stq_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= '0;
      found_q     <= 1'b0;
      fired_q     <= '0;
      hold_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
      ret_q       <= stq_pkg::RET_STOP;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      fired_q     <= fired_d;
      hold_v_q    <= hold_v_d;
      res_valid_q <= emit_v;
      ret_q       <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    was_q     <= was_d;
    cur_q     <= cur_d;
    exp_q     <= exp_d;
    hold_id_q <= hold_id_d;
    if (emit_v) res_q <= emit_res;
  end

  // Order list and expiry table, one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    if (ord_re) ord_rd_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) exp_mem[exp_waddr] <= exp_wdata;
    if (exp_re) exp_rd_q <= exp_mem[exp_raddr];
  end

  `STQ_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, 32'(cnt_q) <= 32'(NUM_TIMERS))
  `STQ_ASSERT_IMPLIES(a_cnt_matches_flags, clk_i, rst_ni, state_q == stq_pkg::ST_IDLE, $countones(pend_q) == 32'(cnt_q))
  `STQ_ASSERT_IMPLIES(a_idle_after_last, clk_i, rst_ni, res_valid_o && !busy, res_o.last)
  `STQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)

endmodule

### tb/sv/tb_sorted_timer_queue_top.sv
module tb_sorted_timer_queue_top;
  import stq_pkg::*;

  localparam int SLOTS      = 16;
  localparam int RAND_ITEMS = 380;
  localparam int CALM_TAIL  = 60;
  localparam logic [TIME_W-1:0] T_MAX = '1;
  // Codes with no command behind them; the block answers them with nothing.
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  typedef struct {
    req_t req;
    bit   pinned;
    res_t pin;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic res_valid;
  res_t res;

  // Typed expectation that travels with the request currently offered.
  bit   pin_on = 1'b0;
  res_t pin_res = '0;

  // Shadow of the timer list.
  logic [TIME_W-1:0] timer_expiry [SLOTS];
  bit                timer_armed [SLOTS];
  logic [ID_W-1:0]   expiry_order [$];

  res_t awaited_events [$];
  res_t cmd_events [$];

  int mismatches;
  int n_requests;
  int n_checked;
  int sweep_len;
  int widest_sweep;
  int seen_kind [8];
  int issued;
  int idle_until;

  // Stimulus side: a loose notion of time and of the last expiry asked per slot.
  logic [TIME_W-1:0] sim_now = 63'd1000;
  logic [TIME_W-1:0] hint_expiry [SLOTS];

  sorted_timer_queue_top #(
    .NUM_TIMERS(SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("tb_sorted_timer_queue_top failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void disarm(input logic [ID_W-1:0] id);
    for (int i = 0; i < expiry_order.size(); i++) begin
      if (expiry_order[i] == id) begin
        expiry_order.delete(i);
        break;
      end
    end
    timer_armed[id] = 1'b0;
  endfunction

  // Goes after every armed timer with an expiry less than or equal to its own.
  function automatic void arm(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] at);
    int pos;
    pos = 0;
    timer_expiry[id] = at;
    while (pos < expiry_order.size() && timer_expiry[expiry_order[pos]] <= at) pos++;
    expiry_order.insert(pos, id);
    timer_armed[id] = 1'b1;
  endfunction

  function automatic res_t make_event(input logic [2:0] kind, input logic [ID_W-1:0] id,
                                      input logic was);
    res_t ev;
    ev = '0;
    ev.event_res = kind;
    ev.event_timer = id;
    ev.was_scheduled = was;
    return ev;
  endfunction

  function automatic void apply_timer_cmd(input req_t r, ref res_t evs[$]);
    res_t ev;
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] target;
    logic [ID_W-1:0] head;
    logic was;
    evs.delete();
    was = timer_armed[r.timer_id];
    case (r.cmd)
      CMD_RUN: begin
        while (expiry_order.size() > 0 && evs.size() < MAX_RESULTS &&
               timer_expiry[expiry_order[0]] < r.now) begin
          head = expiry_order[0];
          disarm(head);
          evs.push_back(make_event(EV_FIRED, head, 1'b1));
        end
        if (evs.size() == 0) evs.push_back(make_event(EV_NOTHING, '0, 1'b0));
      end
      CMD_NEXT: begin
        ev = make_event(EV_NEXT, '0, 1'b0);
        if (expiry_order.size() == 0) begin
          ev.queue_empty = 1'b1;
        end else begin
          head = expiry_order[0];
          ev.event_timer = head;
          if (timer_expiry[head] > r.now) ev.remaining = timer_expiry[head] - r.now;
        end
        evs.push_back(ev);
      end
      CMD_STOP: begin
        if (was) begin
          disarm(r.timer_id);
          evs.push_back(make_event(EV_STOPPED, r.timer_id, 1'b1));
        end else begin
          evs.push_back(make_event(EV_NOTHING, r.timer_id, 1'b0));
        end
      end
      CMD_ADD: begin
        if (was) begin
          evs.push_back(make_event(EV_REJECTED, r.timer_id, 1'b1));
        end else begin
          arm(r.timer_id, r.time_value);
          evs.push_back(make_event(EV_ADDED, r.timer_id, 1'b0));
        end
      end
      CMD_START, CMD_START_DELTA: begin
        target = r.time_value;
        if (r.cmd == CMD_START_DELTA) begin
          sum = {1'b0, r.now} + {1'b0, r.time_value};
          target = sum[TIME_W] ? T_MAX : sum[TIME_W-1:0];
        end
        if (was && timer_expiry[r.timer_id] == target) begin
          evs.push_back(make_event(EV_UNCHANGED, r.timer_id, 1'b1));
        end else begin
          if (was) begin
            disarm(r.timer_id);
            evs.push_back(make_event(EV_STOPPED, r.timer_id, 1'b1));
          end
          arm(r.timer_id, target);
          evs.push_back(make_event(EV_STARTED, r.timer_id, was));
        end
      end
      default: evs.push_back(make_event(EV_NOTHING, '0, 1'b0));
    endcase
    ev = evs.pop_back();
    ev.last = 1'b1;
    evs.push_back(ev);
  endfunction

  task automatic check_event(input res_t got, input res_t want);
    if (got.event_res !== want.event_res)
      report_mismatch($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
    if (got.event_timer !== want.event_timer)
      report_mismatch($sformatf("event_timer got %0d want %0d",
                                got.event_timer, want.event_timer));
    if (got.was_scheduled !== want.was_scheduled)
      report_mismatch($sformatf("was_scheduled got %0b want %0b",
                                got.was_scheduled, want.was_scheduled));
    if (got.remaining !== want.remaining)
      report_mismatch($sformatf("remaining got %0h want %0h", got.remaining, want.remaining));
    if (got.queue_empty !== want.queue_empty)
      report_mismatch($sformatf("queue_empty got %0b want %0b",
                                got.queue_empty, want.queue_empty));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
  endtask

  // Requests are predicted and results checked in one process, so both see
  // the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        apply_timer_cmd(req, cmd_events);
        if (pin_on) begin
          awaited_events.push_back(pin_res);
        end else begin
          foreach (cmd_events[k]) awaited_events.push_back(cmd_events[k]);
        end
        n_requests++;
      end
      if (res_valid) begin
        if (awaited_events.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited, event_res %0d timer %0d",
                                    res.event_res, res.event_timer));
        end else begin
          check_event(res, awaited_events.pop_front());
          n_checked++;
        end
        seen_kind[res.event_res]++;
        if (res.event_res == EV_FIRED) sweep_len++;
        if (res.last) begin
          if (sweep_len > widest_sweep) widest_sweep = sweep_len;
          sweep_len = 0;
        end
      end
    end
  end

  function automatic cmd_row_t free_row(input logic [2:0] cmd, input logic [ID_W-1:0] id,
                                        input logic [TIME_W-1:0] tv,
                                        input logic [TIME_W-1:0] at_now);
    cmd_row_t row;
    row.req.cmd = cmd;
    row.req.timer_id = id;
    row.req.time_value = tv;
    row.req.now = at_now;
    row.pinned = 1'b0;
    row.pin = '0;
    return row;
  endfunction

  function automatic cmd_row_t pin_row(input logic [2:0] cmd, input logic [ID_W-1:0] id,
                                       input logic [TIME_W-1:0] tv,
                                       input logic [TIME_W-1:0] at_now,
                                       input logic [2:0] kind, input logic [ID_W-1:0] ev_id,
                                       input logic was, input logic [TIME_W-1:0] rem,
                                       input logic empty);
    cmd_row_t row;
    row = free_row(cmd, id, tv, at_now);
    row.pinned = 1'b1;
    row.pin = make_event(kind, ev_id, was);
    row.pin.remaining = rem;
    row.pin.queue_empty = empty;
    row.pin.last = 1'b1;
    return row;
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    return {$urandom, $urandom};
  endfunction

  // Mostly small offsets from a slowly advancing now, so runs fire and
  // restarts hit equal expiries; now and then a value anywhere in range.
  function automatic cmd_row_t random_row();
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] tv;
    logic [TIME_W-1:0] at_now;
    int pick;
    pick = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, SLOTS - 1));
    sim_now = sim_now + $urandom_range(0, 40);
    at_now = ($urandom_range(0, 15) == 0) ? any_time() : sim_now;
    if (pick < 25 || (pick >= 40 && pick < 55)) begin
      tv = sim_now + $urandom_range(0, 150);
      if ($urandom_range(0, 4) == 0) tv = hint_expiry[id];
      else if ($urandom_range(0, 15) == 0) tv = any_time();
      else if ($urandom_range(0, 31) == 0) tv = T_MAX;
      hint_expiry[id] = tv;
      return free_row(pick < 25 ? CMD_START : CMD_ADD, id, tv, at_now);
    end
    if (pick < 40) begin
      tv = $urandom_range(0, 150);
      if ($urandom_range(0, 4) == 0 && hint_expiry[id] >= at_now) tv = hint_expiry[id] - at_now;
      else if ($urandom_range(0, 11) == 0) tv = any_time();
      return free_row(CMD_START_DELTA, id, tv, at_now);
    end
    if (pick < 65) return free_row(CMD_STOP, id, any_time(), at_now);
    if (pick < 80) begin
      if ($urandom_range(0, 7) == 0) at_now = sim_now + 200;
      return free_row(CMD_RUN, id, any_time(), at_now);
    end
    if (pick < 95) return free_row(CMD_NEXT, id, any_time(), at_now);
    return free_row($urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B, id, any_time(),
                    any_time());
  endfunction

  task automatic issue(input cmd_row_t row);
    req <= row.req;
    pin_on <= row.pinned;
    pin_res <= row.pin;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    issued++;
    if (issued < idle_until && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  initial begin
    cmd_row_t directed [$];
    int total;
    int base;
    int stride;
    int off;
    int waited;
    logic [ID_W-1:0] id;

    foreach (hint_expiry[i]) hint_expiry[i] = '0;
    foreach (timer_armed[i]) timer_armed[i] = 1'b0;

    directed.push_back(pin_row(CMD_NEXT, 0, 0, 0, EV_NEXT, 0, 0, 0, 1));
    directed.push_back(pin_row(CMD_STOP, 3, 0, 0, EV_NOTHING, 3, 0, 0, 0));
    directed.push_back(pin_row(CMD_RUN, 0, 0, T_MAX, EV_NOTHING, 0, 0, 0, 0));
    directed.push_back(pin_row(CMD_ADD, 0, 0, 0, EV_ADDED, 0, 0, 0, 0));
    directed.push_back(pin_row(CMD_ADD, 0, 5, 0, EV_REJECTED, 0, 1, 0, 0));
    directed.push_back(pin_row(CMD_START, 15, T_MAX, 0, EV_STARTED, 15, 0, 0, 0));
    directed.push_back(pin_row(CMD_START, 15, T_MAX, 0, EV_UNCHANGED, 15, 1, 0, 0));
    directed.push_back(free_row(CMD_START, 15, 100, 0));
    directed.push_back(pin_row(CMD_START_DELTA, 7, T_MAX, T_MAX, EV_STARTED, 7, 0, 0, 0));
    // The sum lands exactly on the top, then goes past it and saturates.
    directed.push_back(pin_row(CMD_START_DELTA, 7, 1, T_MAX - 1, EV_UNCHANGED, 7, 1, 0, 0));
    directed.push_back(pin_row(CMD_START_DELTA, 7, 2, T_MAX - 1, EV_UNCHANGED, 7, 1, 0, 0));
    directed.push_back(pin_row(CMD_ADD, 3, 100, 0, EV_ADDED, 3, 0, 0, 0));
    directed.push_back(pin_row(CMD_START, 9, 100, 0, EV_STARTED, 9, 0, 0, 0));
    directed.push_back(pin_row(CMD_NEXT, 0, 0, 0, EV_NEXT, 0, 0, 0, 0));
    directed.push_back(pin_row(CMD_STOP, 0, 0, 0, EV_STOPPED, 0, 1, 0, 0));
    directed.push_back(pin_row(CMD_NEXT, 0, 0, 40, EV_NEXT, 15, 0, 60, 0));
    directed.push_back(pin_row(CMD_NEXT, 0, 0, 200, EV_NEXT, 15, 0, 0, 0));
    directed.push_back(pin_row(CMD_RUN, 0, 0, 100, EV_NOTHING, 0, 0, 0, 0));
    // Three equal expiries fire in the order they were armed.
    directed.push_back(free_row(CMD_RUN, 0, 0, 101));
    directed.push_back(pin_row(CMD_RUN, 0, 0, T_MAX, EV_NOTHING, 0, 0, 0, 0));
    directed.push_back(pin_row(CMD_RSVD_A, 5, T_MAX, T_MAX, EV_NOTHING, 0, 0, 0, 0));
    directed.push_back(pin_row(CMD_RSVD_B, 15, 0, 0, EV_NOTHING, 0, 0, 0, 0));
    directed.push_back(pin_row(CMD_NEXT, 0, 0, 0, EV_NEXT, 7, 0, T_MAX, 0));
    directed.push_back(pin_row(CMD_STOP, 7, 0, 0, EV_STOPPED, 7, 1, 0, 0));

    total = directed.size() + RAND_ITEMS;
    idle_until = total - CALM_TAIL;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) issue(directed[i]);

    while (issued < total) begin
      if ($urandom_range(0, 19) == 0) begin
        // Arm every slot close together, then sweep them all in one run.
        base = $urandom_range(0, SLOTS - 1);
        stride = 2 * $urandom_range(0, 7) + 1;
        for (int k = 0; k < SLOTS; k++) begin
          id = ID_W'((base + k * stride) % SLOTS);
          off = $urandom_range(0, 7);
          if ($urandom_range(0, 3) == 0) issue(free_row(CMD_START_DELTA, id, off, sim_now));
          else issue(free_row(CMD_START, id, sim_now + off, sim_now));
        end
        issue(free_row(CMD_RUN, '0, any_time(), sim_now + 1000));
      end else begin
        issue(random_row());
      end
    end
    start <= 1'b0;

    waited = 0;
    while ((awaited_events.size() != 0 || busy) && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (64) @(posedge clk_i);
    if (awaited_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_events.size()));
    if (busy) report_mismatch("block still busy after all requests");

    $display("%0d requests, %0d results checked, fullest run fired %0d timers",
             n_requests, n_checked, widest_sweep);
    $display("started %0d stopped %0d fired %0d unchanged %0d added %0d rejected %0d next %0d nothing %0d",
             seen_kind[EV_STARTED], seen_kind[EV_STOPPED], seen_kind[EV_FIRED],
             seen_kind[EV_UNCHANGED], seen_kind[EV_ADDED], seen_kind[EV_REJECTED],
             seen_kind[EV_NEXT], seen_kind[EV_NOTHING]);
    if (mismatches == 0) begin
      $display("tb_sorted_timer_queue_top passed");
    end else begin
      $display("tb_sorted_timer_queue_top failed");
    end
    $finish;
  end

endmodule

### sorted_timer_queue_top.f
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_alu.sv
rtl/sorted_timer_queue_top.sv
tb/sv/tb_sorted_timer_queue_top.sv
